>>> rtl/tone_curve_knot_interpolator_assert.svh
// Assertion macros for the tone curve knot interpolator checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef TONE_CURVE_KNOT_INTERPOLATOR_ASSERT_SVH
`define TONE_CURVE_KNOT_INTERPOLATOR_ASSERT_SVH
// same-cycle implication
`define TCKI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define TCKI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/tcki_pkg.sv
// Package for the tone curve knot interpolator: widths, knot reset ramp,
// queue entry type. No dependencies.
`default_nettype none
package tcki_pkg;
  localparam int FRAC_BITS = 16;
  localparam int KNOTS     = 9;
  localparam int VW        = FRAC_BITS + 1;          // value width
  localparam int KIW       = 4;                      // knot_index field width
  localparam int IW        = $clog2(KNOTS);          // table index width
  localparam int BW        = VW + 2;                 // signed base / multiplicand
  localparam int MAW       = BW;
  localparam int MBW       = VW + 1;                 // signed multiplier
  localparam int PW        = MAW + MBW;              // product width
  localparam int DW        = VW;                     // divisor width
  localparam int CW        = $clog2(PW + 1);         // divide step counter
  localparam int QD        = 2;                      // queue depth
  localparam int QAW       = $clog2(QD);
  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // identity ramp used as the knot reset value
  function automatic logic [VW-1:0] knot_reset(input int idx);
    longint r;
    begin
      r = (longint'(idx) * (longint'(1) << FRAC_BITS)) / (KNOTS - 1);
      knot_reset = r[VW-1:0];
    end
  endfunction

  // one map request: mapped = sat(base + (ma * mb) / den)
  typedef struct packed {
    logic signed [BW-1:0]  base;
    logic signed [MAW-1:0] ma;
    logic signed [MBW-1:0] mb;
    logic        [DW-1:0]  den;
  } op_t;
endpackage
`default_nettype wire

>>> rtl/tcki_if.sv
// Handshake channel interfaces for the tone curve knot interpolator.
// Depends on tcki_pkg.
`default_nettype none
interface tcki_in_if;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [tcki_pkg::KIW-1:0] knot_index;
  logic [tcki_pkg::VW-1:0] knot_x;
  logic [tcki_pkg::VW-1:0] knot_y;
  logic [tcki_pkg::VW-1:0] sample;
  modport source (output valid, opcode, knot_index, knot_x, knot_y, sample, input ready);
  modport sink   (input valid, opcode, knot_index, knot_x, knot_y, sample, output ready);
endinterface

interface tcki_out_if;
  logic                    valid;
  logic                    ready;
  logic [tcki_pkg::VW-1:0] mapped;
  modport source (output valid, mapped, input ready);
  modport sink   (input valid, mapped, output ready);
endinterface
`default_nettype wire

>>> rtl/tcki_queue.sv
// Two-entry request queue between the front and back parts.
// Depends on tcki_pkg.
`default_nettype none
module tcki_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  tcki_pkg::op_t     push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              not_empty,
  output tcki_pkg::op_t     pop_data
);
  tcki_pkg::op_t              mem_r [tcki_pkg::QD];
  logic [tcki_pkg::QAW-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [tcki_pkg::QAW:0]     cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  assign full      = (cnt_r == (tcki_pkg::QAW+1)'(tcki_pkg::QD));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (tcki_pkg::QAW+1)'(do_push) - (tcki_pkg::QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

>>> rtl/tcki_front.sv
// Front part: knot table, request classification, segment search and
// operand selection. Depends on tcki_pkg and tcki_if.
`default_nettype none
module tcki_front (
  input  wire logic     clk,
  input  wire logic     rst_n,
  tcki_in_if.sink       in_ch,
  input  wire logic     q_full,
  output logic          q_push,
  output tcki_pkg::op_t q_data
);
  localparam int K = tcki_pkg::KNOTS;

  logic [tcki_pkg::VW-1:0] kx_r [K];
  logic [tcki_pkg::VW-1:0] ky_r [K];
  logic                    accept, wr_en;
  logic [K-1:0]            le;
  logic                    found;
  logic [tcki_pkg::IW-1:0] sel, sel_m1;
  logic signed [tcki_pkg::BW-1:0] v, x0, y0, xl, yl, xa, ya, xb, yb, lo, hi, dd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign wr_en       = accept && (in_ch.opcode == tcki_pkg::OP_WRITE) &&
                       (in_ch.knot_index < tcki_pkg::KIW'(K));
  assign q_push      = accept && (in_ch.opcode == tcki_pkg::OP_MAP);

  // knot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < K; i++) begin
        kx_r[i] <= tcki_pkg::knot_reset(i);
        ky_r[i] <= tcki_pkg::knot_reset(i);
      end
    end else if (wr_en) begin
      kx_r[in_ch.knot_index[tcki_pkg::IW-1:0]] <= in_ch.knot_x;
      ky_r[in_ch.knot_index[tcki_pkg::IW-1:0]] <= in_ch.knot_y;
    end
  end

  // first segment whose upper knot is at or above the sample
  always_comb begin
    le[0] = 1'b0;
    for (int i = 1; i < K; i++) begin
      le[i] = (in_ch.sample <= kx_r[i]);
    end
    found = |le;
    sel   = tcki_pkg::IW'(1);
    for (int i = K - 1; i >= 1; i--) begin
      if (le[i]) sel = tcki_pkg::IW'(i);
    end
    sel_m1 = sel - 1'b1;
  end

  // operand selection
  always_comb begin
    v  = $signed({2'b00, in_ch.sample});
    x0 = $signed({2'b00, kx_r[0]});
    y0 = $signed({2'b00, ky_r[0]});
    xl = $signed({2'b00, kx_r[K-1]});
    yl = $signed({2'b00, ky_r[K-1]});
    xa = $signed({2'b00, kx_r[sel_m1]});
    ya = $signed({2'b00, ky_r[sel_m1]});
    xb = $signed({2'b00, kx_r[sel]});
    yb = $signed({2'b00, ky_r[sel]});
    lo = ya - xa;
    hi = yb - xb;
    dd = '0;
    q_data = '0;
    priority if (v <= x0) begin
      q_data.base = '0;
      q_data.ma   = y0;
      q_data.mb   = v[tcki_pkg::MBW-1:0];
      q_data.den  = (x0 < 1) ? tcki_pkg::DW'(1) : x0[tcki_pkg::DW-1:0];
    end else if (v >= xl) begin
      dd          = $signed({2'b00, tcki_pkg::ONE}) - xl;
      q_data.base = yl;
      q_data.ma   = $signed({2'b00, tcki_pkg::ONE}) - yl;
      q_data.mb   = tcki_pkg::MBW'(v - xl);
      q_data.den  = (dd < 1) ? tcki_pkg::DW'(1) : dd[tcki_pkg::DW-1:0];
    end else if (found) begin
      dd          = xb - xa;
      q_data.base = v + lo;
      q_data.ma   = hi - lo;
      q_data.mb   = tcki_pkg::MBW'(v - xa);
      q_data.den  = (dd < 1) ? tcki_pkg::DW'(1) : dd[tcki_pkg::DW-1:0];
    end else begin
      // fallback, last knot y; not reached, as the last knot lies above the sample here
      q_data.base = yl;
      q_data.ma   = '0;
      q_data.mb   = '0;
      q_data.den  = tcki_pkg::DW'(1);
    end
  end
endmodule
`default_nettype wire

>>> rtl/tcki_back.sv
// Back part: multiply, bit-serial divide, saturate and output register.
// Depends on tcki_pkg and tcki_if.
`default_nettype none
module tcki_back (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_not_empty,
  input  tcki_pkg::op_t q_data,
  output logic          q_pop,
  tcki_out_if.source    out_ch
);
  localparam int PW = tcki_pkg::PW;
  localparam int DW = tcki_pkg::DW;
  localparam int VW = tcki_pkg::VW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  tcki_pkg::op_t             op_r;
  logic signed [PW-1:0]      prod;
  logic                      neg_r;
  logic [DW:0]               rem_r, rem_nxt, trial;
  logic [PW-1:0]             quo_r, quo_nxt;
  logic [tcki_pkg::CW-1:0]   cnt_r, cnt_nxt;
  logic signed [PW:0]        qs, sum;
  logic [VW-1:0]             sat;
  logic                      out_free, load_out;
  logic                      out_valid_r;
  logic [VW-1:0]             mapped_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = (state_r == ST_IDLE) && q_not_empty;
  assign load_out = (state_r == ST_DONE) && out_free;
  assign prod     = $signed(op_r.ma) * $signed(op_r.mb);

  // one quotient bit per step
  always_comb begin
    trial = {rem_r[DW-1:0], quo_r[PW-1]};
    if (trial >= {1'b0, op_r.den}) begin
      rem_nxt = trial - {1'b0, op_r.den};
      quo_nxt = {quo_r[PW-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      quo_nxt = {quo_r[PW-2:0], 1'b0};
    end
  end

  // sign, offset, saturation
  always_comb begin
    qs  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    sum = qs + (PW+1)'(op_r.base);
    if (sum < 0) begin
      sat = '0;
    end else if (sum > $signed({{(PW+1-VW){1'b0}}, tcki_pkg::ONE})) begin
      sat = tcki_pkg::ONE;
    end else begin
      sat = sum[VW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: if (q_not_empty) state_nxt = ST_MUL;
      ST_MUL: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tcki_pkg::CW'(PW - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) op_r <= q_data;
    if (state_r == ST_MUL) begin
      neg_r <= prod[PW-1];
      quo_r <= prod[PW-1] ? PW'(-prod) : PW'(prod);
      rem_r <= '0;
    end else if (state_r == ST_DIV) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (load_out) mapped_r <= sat;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.mapped = mapped_r;
endmodule
`default_nettype wire

>>> rtl/tone_curve_knot_interpolator.sv
// Channel    | Dir | Payload
// in_ch      | in  | opcode, knot_index, knot_x, knot_y, sample
// out_ch     | out | mapped (one per map request, none per knot write)
//
// A knot write is taken at the front and does not enter the queue. A map request
// passes in the back through one pop, one multiply, 37 divide steps of the bit-serial
// divider and one saturate and load; the divider sets the rate unless the output stalls.
// The two-entry queue lets the front take requests while the back works.
// Synchronous active-low reset restores the identity knot ramp.
`default_nettype none
module tone_curve_knot_interpolator (
  input wire logic clk,
  input wire logic rst_n,
  tcki_in_if.sink    in_ch,
  tcki_out_if.source out_ch
);
  tcki_pkg::op_t push_data, pop_data;
  logic          q_full, q_push, q_pop, q_not_empty;

  tcki_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_full(q_full), .q_push(q_push), .q_data(push_data)
  );

  tcki_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(push_data),
    .full(q_full), .pop(q_pop), .not_empty(q_not_empty), .pop_data(pop_data)
  );

  tcki_back u_back (
    .clk(clk), .rst_n(rst_n), .q_not_empty(q_not_empty), .q_data(pop_data),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

>>> rtl/tcki_checker.sv
// Port-level checker for the tone curve knot interpolator, bound to the top.
// Depends on tcki_pkg and the assertion macro header.
`default_nettype none
`include "tone_curve_knot_interpolator_assert.svh"
module tcki_checker (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [tcki_pkg::VW-1:0] out_mapped
);
  `TCKI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_mapped), "result dropped or changed while stalled")
  `TCKI_ASSERT_NOW(a_out_range, out_valid, out_mapped <= tcki_pkg::ONE, "result above one")
  `TCKI_ASSERT_NOW(a_rst_out, $past(!rst_n), !out_valid, "result valid right after reset")
  `TCKI_ASSERT_NOW(a_rst_ready, $past(!rst_n), in_ready, "not ready right after reset")
endmodule

bind tone_curve_knot_interpolator tcki_checker u_tcki_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_mapped(out_ch.mapped)
);
`default_nettype wire
